/* hw/rtl/lsds_pkg.sv */
// Shared types, widths and constants of the lidar sector distance smoother.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package lsds_pkg;

  // Fractional bits of the averaged distance.
  localparam int FRAC_BITS = 8;

  // Field widths.
  localparam int DIST_W    = 14;
  localparam int ANGLE_W   = 15;
  localparam int TURNS_W   = 8;
  localparam int HEAD_W    = 16;
  localparam int WEIGHT_W  = 16;
  localparam int WIN_W     = 13;
  localparam int STORE_W   = 22;
  localparam int HIT_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = WEIGHT_W;

  // Packed beat widths, rounded up to whole bytes.
  localparam int IN_FIELDS_W  = DIST_W + ANGLE_W + TURNS_W + HEAD_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * STORE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Angle arithmetic in 1/64 degree.
  localparam int TURN_UNITS    = 23040;
  localparam int QUARTER_UNITS = 5760;
  localparam int RIGHT_CENTER  = 5760;
  localparam int LEFT_CENTER   = 17280;
  // Bias of two full turns keeps the corrected sum positive.
  localparam int ANGLE_BIAS    = 2 * TURN_UNITS;
  localparam int SUM_W         = 18;
  localparam int WRAP_STEPS    = 5;
  localparam int CMP_W         = ANGLE_W + 1;

  // Moving average datapath.
  localparam int SAMPLE_W = DIST_W + FRAC_BITS;
  localparam int OLD_PROD_W = WEIGHT_W + STORE_W;
  localparam int NEW_PROD_W = WEIGHT_W + 1 + SAMPLE_W;
  localparam int ACC_W = ((OLD_PROD_W > NEW_PROD_W) ? OLD_PROD_W : NEW_PROD_W) + 1;
  localparam int RES_W = ACC_W - WEIGHT_W;

  // Reset values of the configuration registers.
  localparam logic [WEIGHT_W-1:0] KEEP_WEIGHT_RST  = WEIGHT_W'(655);
  localparam logic [DIST_W-1:0]   MIN_DISTANCE_RST = DIST_W'(10);
  localparam logic [DIST_W-1:0]   MAX_DISTANCE_RST = DIST_W'(3000);
  localparam logic [WIN_W-1:0]    WINDOW_WIDTH_RST = WIN_W'(640);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEEP_WEIGHT  = 2'd0,
    CFG_MIN_DISTANCE = 2'd1,
    CFG_MAX_DISTANCE = 2'd2,
    CFG_WINDOW_WIDTH = 2'd3
  } cfg_idx_t;

  typedef enum logic [HIT_W-1:0] {
    HIT_RANGE = 3'd0,
    HIT_FRONT = 3'd1,
    HIT_RIGHT = 3'd2,
    HIT_LEFT  = 3'd3,
    HIT_NONE  = 3'd4
  } sector_hit_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] keep_weight;
    logic [DIST_W-1:0]   min_distance;
    logic [DIST_W-1:0]   max_distance;
    logic [WIN_W-1:0]    window_width;
  } cfg_regs_t;

  // Classification of one point, handed from the sector stage to the average stage.
  typedef struct packed {
    sector_hit_t       hit;
    logic [DIST_W-1:0] dist_mm;
  } sect_info_t;

endpackage

`default_nettype wire

/* hw/rtl/lidar_sector_distance_smoother_top.sv */
// Top level of the lidar sector distance smoother: beat pipeline, config and stores.
// Depends on lsds_pkg, lsds_sector_class and lsds_ema_update.
//
// Usage:
//   in_*  : one scanner point per beat. in_tdata holds distance_mm, raw_angle,
//           quarter_turns and heading, packed from bit 0 up.
//   out_* : one result beat per point, in order. out_tdata holds the front,
//           right and left averages (mm, 8 fraction bits); out_tuser is the
//           sector hit code (rejected by range, front, right, left, no sector).
//   cfg_* : register writes (keep_weight, min_distance, max_distance,
//           window_width). cfg_ready is always high; write only while no point
//           is in flight.
// Pipeline: three register stages (input register, sector register, output
// register); a point taken at the input moves on through the sector register
// into the output register, where its result beat is presented.
// Throughput: one point per cycle while the receiver does not stall. The average
// update of a sector store is combinational (one weight multiply per term),
// so a point that hits the same sector as the one just before it never waits.
// Reset: all three averages go to zero, the registers to their defaults, and
// the pipeline empties. When the receiver stalls, each stage holds its beat;
// the input keeps being taken until every stage is full.
`default_nettype none

module lidar_sector_distance_smoother_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // [13:0] distance_mm, [28:14] raw_angle, [36:29] quarter_turns, [52:37] heading
  input  wire logic [lsds_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [21:0] front_avg, [43:22] right_avg, [65:44] left_avg
  output logic      [lsds_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [2:0] sector_hit
  output logic      [lsds_pkg::HIT_W-1:0]         out_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lsds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lsds_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int RAW_LO   = lsds_pkg::DIST_W;
  localparam int TURNS_LO = RAW_LO + lsds_pkg::ANGLE_W;
  localparam int HEAD_LO  = TURNS_LO + lsds_pkg::TURNS_W;

  // Configuration registers.
  lsds_pkg::cfg_regs_t cfg_r;

  // Stage 1: registered input point.
  logic                                   s1_valid_r;
  logic [lsds_pkg::DIST_W-1:0]            s1_dist_r;
  logic [lsds_pkg::ANGLE_W-1:0]           s1_raw_r;
  logic signed [lsds_pkg::TURNS_W-1:0]    s1_turns_r;
  logic signed [lsds_pkg::HEAD_W-1:0]     s1_head_r;

  // Stage 2: sector decision.
  logic                 s2_valid_r;
  lsds_pkg::sect_info_t s2_info_r;
  lsds_pkg::sect_info_t s2_info_nxt;

  // Stage 3: output register and the sector stores.
  logic                               out_valid_r;
  logic [lsds_pkg::STORE_W-1:0]       front_r, right_r, left_r;
  logic [lsds_pkg::STORE_W-1:0]       front_nxt, right_nxt, left_nxt;
  logic [lsds_pkg::STORE_W-1:0]       out_front_r, out_right_r, out_left_r;
  lsds_pkg::sector_hit_t              out_hit_r;
  logic [lsds_pkg::STORE_W-1:0]       old_sel;
  logic [lsds_pkg::STORE_W-1:0]       avg_upd;

  logic out_adv;
  logic s2_ready;
  logic s1_ready;
  logic in_fire;
  logic s2_load;
  logic s3_load;

  // Each stage advances when the one after it has room.
  assign out_adv   = !out_valid_r || out_tready;
  assign s2_ready  = !s2_valid_r || out_adv;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;
  assign in_fire   = in_tvalid && s1_ready;
  assign s2_load   = s1_valid_r && s2_ready;
  assign s3_load   = s2_valid_r && out_adv;
  assign cfg_ready = 1'b1;

  // Config writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.keep_weight  <= lsds_pkg::KEEP_WEIGHT_RST;
      cfg_r.min_distance <= lsds_pkg::MIN_DISTANCE_RST;
      cfg_r.max_distance <= lsds_pkg::MAX_DISTANCE_RST;
      cfg_r.window_width <= lsds_pkg::WINDOW_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lsds_pkg::cfg_idx_t'(cfg_index))
        lsds_pkg::CFG_KEEP_WEIGHT:  cfg_r.keep_weight  <= cfg_data;
        lsds_pkg::CFG_MIN_DISTANCE: cfg_r.min_distance <= cfg_data[lsds_pkg::DIST_W-1:0];
        lsds_pkg::CFG_MAX_DISTANCE: cfg_r.max_distance <= cfg_data[lsds_pkg::DIST_W-1:0];
        lsds_pkg::CFG_WINDOW_WIDTH: cfg_r.window_width <= cfg_data[lsds_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_adv) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Stage 1 payload: unpack the beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_dist_r  <= in_tdata[RAW_LO-1:0];
      s1_raw_r   <= in_tdata[TURNS_LO-1:RAW_LO];
      s1_turns_r <= in_tdata[HEAD_LO-1:TURNS_LO];
      s1_head_r  <= in_tdata[HEAD_LO+lsds_pkg::HEAD_W-1:HEAD_LO];
    end
  end

  lsds_sector_class u_sector (
    .distance_mm   (s1_dist_r),
    .raw_angle     (s1_raw_r),
    .quarter_turns (s1_turns_r),
    .heading       (s1_head_r),
    .cfg           (cfg_r),
    .info          (s2_info_nxt)
  );

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_info_r <= s2_info_nxt;
    end
  end

  // Pick the store that this point updates.
  always_comb begin
    unique case (s2_info_r.hit)
      lsds_pkg::HIT_RIGHT: old_sel = right_r;
      lsds_pkg::HIT_LEFT:  old_sel = left_r;
      default:             old_sel = front_r;
    endcase
  end

  lsds_ema_update u_ema (
    .keep_weight (cfg_r.keep_weight),
    .old_avg     (old_sel),
    .distance_mm (s2_info_r.dist_mm),
    .new_avg     (avg_upd)
  );

  always_comb begin
    front_nxt = front_r;
    right_nxt = right_r;
    left_nxt  = left_r;
    unique case (s2_info_r.hit)
      lsds_pkg::HIT_FRONT: front_nxt = avg_upd;
      lsds_pkg::HIT_RIGHT: right_nxt = avg_upd;
      lsds_pkg::HIT_LEFT:  left_nxt  = avg_upd;
      default: ;
    endcase
  end

  // Stores advance only as their beat moves into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      right_r <= '0;
      left_r  <= '0;
    end else if (s3_load) begin
      front_r <= front_nxt;
      right_r <= right_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      out_front_r <= front_nxt;
      out_right_r <= right_nxt;
      out_left_r  <= left_nxt;
      out_hit_r   <= s2_info_r.hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(lsds_pkg::OUT_DATA_W - lsds_pkg::OUT_FIELDS_W)'(0),
                       out_left_r, out_right_r, out_front_r};
  assign out_tuser  = out_hit_r;

endmodule

`default_nettype wire

/* hw/rtl/lsds_sector_class.sv */
// Range check, heading correction with wrap into one turn, and sector pick.
// Depends on lsds_pkg.
`default_nettype none

module lsds_sector_class (
  input  wire logic [lsds_pkg::DIST_W-1:0]         distance_mm,
  input  wire logic [lsds_pkg::ANGLE_W-1:0]        raw_angle,
  input  wire logic signed [lsds_pkg::TURNS_W-1:0] quarter_turns,
  input  wire logic signed [lsds_pkg::HEAD_W-1:0]  heading,
  input  wire lsds_pkg::cfg_regs_t                 cfg,
  output lsds_pkg::sect_info_t                     info
);

  always_comb begin
    logic [lsds_pkg::SUM_W-1:0]   qoff;
    logic [lsds_pkg::SUM_W-1:0]   sum;
    logic [lsds_pkg::SUM_W-1:0]   wrapped;
    logic [lsds_pkg::ANGLE_W-1:0] ang;
    logic [lsds_pkg::CMP_W-1:0]   a16;
    logic [lsds_pkg::CMP_W-1:0]   w16;
    logic                         in_range;
    logic                         front;
    logic                         right;
    logic                         left;

    // Whole turns drop out modulo 360 degrees, so only the low two bits count.
    unique case (quarter_turns[1:0])
      2'd0:    qoff = '0;
      2'd1:    qoff = lsds_pkg::SUM_W'(lsds_pkg::QUARTER_UNITS);
      2'd2:    qoff = lsds_pkg::SUM_W'(2 * lsds_pkg::QUARTER_UNITS);
      default: qoff = lsds_pkg::SUM_W'(3 * lsds_pkg::QUARTER_UNITS);
    endcase

    sum = lsds_pkg::SUM_W'(raw_angle) + qoff + lsds_pkg::SUM_W'(lsds_pkg::ANGLE_BIAS)
        - lsds_pkg::SUM_W'(heading);

    // Subtract the largest whole multiple of a turn that fits.
    wrapped = sum;
    for (int k = 1; k <= lsds_pkg::WRAP_STEPS; k++) begin
      if (sum >= lsds_pkg::SUM_W'(k * lsds_pkg::TURN_UNITS)) begin
        wrapped = sum - lsds_pkg::SUM_W'(k * lsds_pkg::TURN_UNITS);
      end
    end
    ang = wrapped[lsds_pkg::ANGLE_W-1:0];

    a16 = lsds_pkg::CMP_W'(ang);
    w16 = lsds_pkg::CMP_W'(cfg.window_width);

    in_range = (distance_mm >= cfg.min_distance) && (distance_mm <= cfg.max_distance);
    front = (a16 < w16) || (a16 > lsds_pkg::CMP_W'(lsds_pkg::TURN_UNITS) - w16);
    right = (a16 > lsds_pkg::CMP_W'(lsds_pkg::RIGHT_CENTER))
         && (a16 < lsds_pkg::CMP_W'(lsds_pkg::RIGHT_CENTER) + w16);
    left  = (a16 < lsds_pkg::CMP_W'(lsds_pkg::LEFT_CENTER))
         && (a16 > lsds_pkg::CMP_W'(lsds_pkg::LEFT_CENTER) - w16);

    info.dist_mm = distance_mm;
    priority if (!in_range) begin
      info.hit = lsds_pkg::HIT_RANGE;
    end else if (front) begin
      info.hit = lsds_pkg::HIT_FRONT;
    end else if (right) begin
      info.hit = lsds_pkg::HIT_RIGHT;
    end else if (left) begin
      info.hit = lsds_pkg::HIT_LEFT;
    end else begin
      info.hit = lsds_pkg::HIT_NONE;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lsds_ema_update.sv */
// One exponential moving average step: two multiplies, round half up, saturate.
// Depends on lsds_pkg.
`default_nettype none

module lsds_ema_update (
  input  wire logic [lsds_pkg::WEIGHT_W-1:0] keep_weight,
  input  wire logic [lsds_pkg::STORE_W-1:0]  old_avg,
  input  wire logic [lsds_pkg::DIST_W-1:0]   distance_mm,
  output logic      [lsds_pkg::STORE_W-1:0]  new_avg
);

  always_comb begin
    logic [lsds_pkg::SAMPLE_W-1:0]   sample;
    logic [lsds_pkg::WEIGHT_W:0]     take_weight;
    logic [lsds_pkg::OLD_PROD_W-1:0] old_prod;
    logic [lsds_pkg::NEW_PROD_W-1:0] new_prod;
    logic [lsds_pkg::ACC_W-1:0]      acc;
    logic [lsds_pkg::RES_W-1:0]      res;

    sample      = lsds_pkg::SAMPLE_W'(distance_mm) << lsds_pkg::FRAC_BITS;
    take_weight = (lsds_pkg::WEIGHT_W+1)'(1 << lsds_pkg::WEIGHT_W)
                - (lsds_pkg::WEIGHT_W+1)'(keep_weight);
    old_prod    = lsds_pkg::OLD_PROD_W'(keep_weight) * lsds_pkg::OLD_PROD_W'(old_avg);
    new_prod    = lsds_pkg::NEW_PROD_W'(take_weight) * lsds_pkg::NEW_PROD_W'(sample);
    acc = lsds_pkg::ACC_W'(old_prod) + lsds_pkg::ACC_W'(new_prod)
        + lsds_pkg::ACC_W'(1 << (lsds_pkg::WEIGHT_W - 1));
    res = acc[lsds_pkg::ACC_W-1:lsds_pkg::WEIGHT_W];

    if (|res[lsds_pkg::RES_W-1:lsds_pkg::STORE_W]) begin
      new_avg = '1;
    end else begin
      new_avg = res[lsds_pkg::STORE_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lsds_checker.sv */
// Port-level checks of the lidar sector distance smoother, bound to its top level.
// Depends on lsds_pkg and lidar_sector_distance_smoother_top.
`default_nettype none

module lsds_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic [lsds_pkg::IN_DATA_W-1:0]     in_tdata,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic [lsds_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire logic [lsds_pkg::HIT_W-1:0]         out_tuser,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic                               cfg_valid,
  input wire logic                               cfg_ready,
  input wire logic [lsds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire logic [lsds_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW = lsds_pkg::STORE_W;

  logic          out_fire;
  logic [SW-1:0] last_front_r, last_right_r, last_left_r;
  logic [SW-1:0] cur_front, cur_right, cur_left;

  assign out_fire  = out_tvalid && out_tready;
  assign cur_front = out_tdata[SW-1:0];
  assign cur_right = out_tdata[2*SW-1:SW];
  assign cur_left  = out_tdata[3*SW-1:2*SW];

  // Track the averages of the previous result beat; they start at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_front_r <= '0;
      last_right_r <= '0;
      last_left_r  <= '0;
    end else if (out_fire) begin
      last_front_r <= cur_front;
      last_right_r <= cur_right;
      last_left_r  <= cur_left;
    end
  end

  // Only the sector that was hit may change between result beats.
  a_untouched_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |->
      (out_tuser == lsds_pkg::HIT_FRONT || cur_front == last_front_r) &&
      (out_tuser == lsds_pkg::HIT_RIGHT || cur_right == last_right_r) &&
      (out_tuser == lsds_pkg::HIT_LEFT  || cur_left  == last_left_r))
    else $error("average of an unhit sector changed");

  // An empty output side never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

endmodule

bind lidar_sector_distance_smoother_top lsds_checker u_lsds_checker (.*);

`default_nettype wire
